// ----- hw/rtl/sbph_pkg.sv -----
// Shared types, constants and helper function of the spectrum bar peak-hold block.
`default_nettype none

package sbph_pkg;

    localparam int MAX_BANDS         = 8;
    localparam int MAX_LEDS_PER_BAND = 32;
    localparam int FULL_SCALE_SHIFT  = 12;
    localparam int FULL_SCALE        = (1 << FULL_SCALE_SHIFT) - 1;

    localparam int OP_W     = 3;
    localparam int BAND_W   = 3;
    localparam int LEVEL_W  = 12;
    localparam int PIX_W    = 5;
    localparam int COLOR_W  = 24;
    localparam int BCNT_W   = 4;
    localparam int LEDS_W   = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int PROD_W   = LEVEL_W + LEDS_W;

    localparam logic [OP_W-1:0] OP_SET_LEVEL = 3'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE    = 3'd1;
    localparam logic [OP_W-1:0] OP_DECAY     = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd3;
    localparam logic [OP_W-1:0] OP_RENDER    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_BAND_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEDS_PER_BAND = 2'd1;

    localparam logic [BCNT_W-1:0] BAND_COUNT_RESET = 4'd7;
    localparam logic [LEDS_W-1:0] LEDS_RESET       = 6'd16;

    localparam logic [COLOR_W-1:0] COLOR_BLUE  = 24'h0000FF;
    localparam logic [COLOR_W-1:0] COLOR_PEAK  = 24'h440000;
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 24'h000000;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [BAND_W-1:0]  band;
        logic [LEVEL_W-1:0] level;
    } t_item;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_index;
        logic [COLOR_W-1:0] pixel_color;
        logic               last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_BAR,
        S_PEAK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load_item;
        logic idx_clr;
        logic idx_inc;
        logic wr_level;
        logic peak_raise;
        logic peak_dec;
        logic peak_clr;
        logic calc_bar;
        logic calc_peak;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            band_ok;
        logic            no_bands;
        logic            leds_ok;
        logic            walk_last;
        logic            emit_last;
    } t_dp_stat;

    // floor(value * leds / FULL_SCALE) using FULL_SCALE = 2^n - 1: the
    // remainder after the shift estimate stays below twice the divisor.
    function automatic logic [LEDS_W:0] scale_to_leds(input logic [LEVEL_W-1:0] value,
                                                      input logic [LEDS_W-1:0] leds);
        logic [PROD_W-1:0]          prod;
        logic [LEDS_W:0]            q0;
        logic [FULL_SCALE_SHIFT:0]  rem;
        logic [LEDS_W:0]            q;
        prod = PROD_W'(value) * PROD_W'(leds);
        q0   = (LEDS_W+1)'(prod >> FULL_SCALE_SHIFT);
        rem  = (FULL_SCALE_SHIFT+1)'(prod[FULL_SCALE_SHIFT-1:0])
               + (FULL_SCALE_SHIFT+1)'(q0);
        q    = q0 + ((rem >= (FULL_SCALE_SHIFT+1)'(FULL_SCALE)) ? (LEDS_W+1)'(1)
                                                                 : (LEDS_W+1)'(0));
        if (q > {1'b0, leds}) begin
            q = {1'b0, leds};
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sbph_ctrl.sv -----
// Controller state machine that sequences band walks and pixel rendering.
`default_nettype none

module sbph_ctrl
    import sbph_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.op) inside
                    OP_SAMPLE, OP_DECAY, OP_CLEAR: begin
                        n_state = i_stat.no_bands ? S_IDLE : S_WALK;
                    end
                    OP_RENDER: begin
                        n_state = (i_stat.band_ok && i_stat.leds_ok) ? S_BAR : S_IDLE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_WALK: begin
                if (i_stat.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_BAR: begin
                n_state = S_PEAK;
            end
            S_PEAK: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy            = 1'b0;
                o_cmd.load_item = start;
            end
            S_DECODE: begin
                o_cmd.idx_clr  = 1'b1;
                o_cmd.wr_level = (i_stat.op == OP_SET_LEVEL) && i_stat.band_ok;
                if (i_stat.op == OP_RENDER) begin
                    o_cmd.idx_clr = 1'b0;
                end
            end
            S_WALK: begin
                o_cmd.idx_inc    = 1'b1;
                o_cmd.peak_raise = (i_stat.op == OP_SAMPLE);
                o_cmd.peak_dec   = (i_stat.op == OP_DECAY);
                o_cmd.peak_clr   = (i_stat.op == OP_CLEAR);
            end
            S_BAR: begin
                o_cmd.calc_bar = 1'b1;
            end
            S_PEAK: begin
                o_cmd.calc_peak = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    a_walk_needs_bands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> !i_stat.no_bands)
        else $error("band walk running with no bands in use");

    a_emit_needs_leds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> i_stat.leds_ok && i_stat.band_ok)
        else $error("pixel emission on an unused band or empty bar");

    a_peak_follows_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BAR |=> r_state == S_PEAK)
        else $error("peak position step skipped after bar length step");

endmodule

`default_nettype wire

// ----- hw/rtl/sbph_dp.sv -----
// Datapath with band levels, held peaks, configuration registers, scaler and pixel output.
`default_nettype none

module sbph_dp
    import sbph_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_item                 i_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    output logic                       o_strobe,
    output t_result                    o_result
);

    logic [LEVEL_W-1:0] r_level_mem [MAX_BANDS];
    logic [LEVEL_W-1:0] r_peak_mem  [MAX_BANDS];
    logic [BCNT_W-1:0]  r_band_count;
    logic [LEDS_W-1:0]  r_leds;
    logic [OP_W-1:0]    r_op;
    logic [LEVEL_W-1:0] r_level;
    logic [BAND_W-1:0]  r_idx;
    logic [LEDS_W-1:0]  r_bar;
    logic [PIX_W-1:0]   r_peak_pos;
    logic [PIX_W-1:0]   r_pix;

    logic [BCNT_W-1:0]  nb;
    logic [LEDS_W-1:0]  leds;
    logic [LEVEL_W-1:0] cur_level;
    logic [LEVEL_W-1:0] cur_peak;
    logic [LEVEL_W-1:0] scale_in;
    logic [LEDS_W:0]    scaled;
    logic [LEDS_W:0]    peak_pos;
    logic [COLOR_W-1:0] color;

    assign nb   = (r_band_count > BCNT_W'(MAX_BANDS)) ? BCNT_W'(MAX_BANDS) : r_band_count;
    assign leds = (r_leds > LEDS_W'(MAX_LEDS_PER_BAND)) ? LEDS_W'(MAX_LEDS_PER_BAND) : r_leds;

    assign cur_level = r_level_mem[r_idx];
    assign cur_peak  = r_peak_mem[r_idx];
    assign scale_in  = i_cmd.calc_peak ? cur_peak : cur_level;
    assign scaled    = scale_to_leds(scale_in, leds);
    assign peak_pos  = (scaled >= {1'b0, leds}) ? ({1'b0, leds} - (LEDS_W+1)'(1)) : scaled;

    always_comb begin
        if (r_pix == r_peak_pos) begin
            color = COLOR_PEAK;
        end else if (LEDS_W'(r_pix) < r_bar) begin
            color = COLOR_BLUE;
        end else begin
            color = COLOR_BLACK;
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.band_ok   = BCNT_W'(r_idx) < nb;
    assign o_stat.no_bands  = (nb == '0);
    assign o_stat.leds_ok   = (leds != '0);
    assign o_stat.walk_last = BCNT_W'(r_idx) == (nb - BCNT_W'(1));
    assign o_stat.emit_last = LEDS_W'(r_pix) == (leds - LEDS_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_BANDS; i++) begin
                r_level_mem[i] <= '0;
                r_peak_mem[i]  <= '0;
            end
            r_band_count <= BAND_COUNT_RESET;
            r_leds       <= LEDS_RESET;
            r_idx        <= '0;
            o_strobe     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BAND_COUNT:    r_band_count <= i_cfg_data[BCNT_W-1:0];
                    REG_LEDS_PER_BAND: r_leds       <= i_cfg_data[LEDS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_item) begin
                r_idx <= i_item.band;
            end else if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + BAND_W'(1);
            end
            if (i_cmd.wr_level) begin
                r_level_mem[r_idx] <= r_level;
            end
            if (i_cmd.peak_raise && (cur_level > cur_peak)) begin
                r_peak_mem[r_idx] <= cur_level;
            end else if (i_cmd.peak_dec && (cur_peak != '0)) begin
                r_peak_mem[r_idx] <= cur_peak - LEVEL_W'(1);
            end else if (i_cmd.peak_clr) begin
                r_peak_mem[r_idx] <= '0;
            end
            o_strobe <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op    <= i_item.operation;
            r_level <= i_item.level;
        end
        if (i_cmd.calc_bar) begin
            r_bar <= scaled[LEDS_W-1:0];
        end
        if (i_cmd.calc_peak) begin
            r_peak_pos <= peak_pos[PIX_W-1:0];
            r_pix      <= '0;
        end
        if (i_cmd.emit) begin
            r_pix                <= r_pix + PIX_W'(1);
            o_result.pixel_index <= r_pix;
            o_result.pixel_color <= color;
            o_result.last        <= o_stat.emit_last;
        end
    end

    a_bar_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_bar <= leds)
        else $error("bar length beyond the band");

    a_peak_in_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> LEDS_W'(r_peak_pos) < leds)
        else $error("peak pixel outside the band");

    a_decay_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.peak_dec && cur_peak == '0 |=> r_peak_mem[$past(r_idx)] == '0)
        else $error("peak decay wrapped below zero");

endmodule

`default_nettype wire

// ----- hw/rtl/spectrum_bar_peak_hold_core.sv -----
// Top level of the spectrum bar graph with per-band peak hold.
`default_nettype none

// An item is taken when start is high and busy is low; busy then stays high
// until the item is done. Set level is written in the decode state; sample
// complete, decay tick and clear peaks walk the bands in use, one band per
// cycle through the single level and peak port. Render band computes the bar
// and peak position, then gives one pixel item per cycle on o_strobe, in the
// cycle after the controller produces it. Results cannot be held off: the
// receiver must take every strobed item in the cycle it appears.
module spectrum_bar_peak_hold_core
    import sbph_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire t_item                 i_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_strobe,
    output t_result                    o_result
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    sbph_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    sbph_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

    a_strobe_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result item without an item in progress");

    a_pixels_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |=> o_strobe &&
            o_result.pixel_index == PIX_W'($past(o_result.pixel_index) + PIX_W'(1)))
        else $error("pixel run broken before its last pixel");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |=> !o_strobe)
        else $error("pixel item after the last pixel");

endmodule

`default_nettype wire
